@@ rtl/swcm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcm_pkg
// Shared types and constants for the stopwatch with clock mode block.
// ----------------------------------------------------------------------------
package swcm_pkg;

	// event and result payloads as they appear on the ports
	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] now_ms;
	} evt_item_t;

	typedef struct packed {
		logic       refresh;
		logic       timer_mode;
		logic [1:0] run_state;
		logic [7:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic       started;
	} res_item_t;

	// event kinds
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_MODE  = 2'd1,
		CMD_START = 2'd2,
		CMD_RESET = 2'd3
	} cmd_t;

	// timer states
	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_RUNNING = 2'd1,
		ST_PAUSED  = 2'd2
	} run_state_t;

	// classified event as it sits in the queue
	typedef struct packed {
		cmd_t        kind;
		logic [31:0] now_ms;
	} op_t;

	// status carried down the conversion pipeline
	typedef struct packed {
		logic       refresh;
		logic       timer_mode;
		run_state_t run_state;
		logic       started;
	} flags_t;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [15:0] REFRESH_PERIOD_RST = 16'd1000;

	// floor(x / 1000) for 32-bit x: (x * ceil(2^38 / 1000)) >> 38
	localparam logic [28:0] MS_RECIP = 29'd274877907;
	localparam int unsigned MS_SHIFT = 38;
	localparam int unsigned SECS_W   = 23;

	// floor(x / 60) for x < 6100806, which covers every seconds count of a 32-bit ms value: (x * ceil(2^28 / 60)) >> 28
	localparam logic [22:0] SEC_RECIP = 23'd4473925;
	localparam int unsigned SEC_SHIFT = 28;
	localparam int unsigned MINS_W    = 17;

	// floor(x / 60) for x < 74899, which covers every minutes count of a 32-bit ms value: (x * ceil(2^22 / 60)) >> 22
	localparam logic [16:0] MIN_RECIP = 17'd69906;
	localparam int unsigned MIN_SHIFT = 22;
	localparam int unsigned HRS_W     = 11;

endpackage

@@ rtl/swcm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcm_front
// Takes events off the input channel, classifies them and pushes them into
// the queue. Stalls the source while the queue is full.
// ----------------------------------------------------------------------------
module swcm_front (
	input  logic                 evt_valid,
	output logic                 evt_stall,
	input  swcm_pkg::evt_item_t  evt,
	input  logic                 q_full,
	output logic                 q_push,
	output swcm_pkg::op_t        q_wdata
);

	// back pressure straight from the queue fill state
	assign evt_stall = q_full;
	assign q_push    = evt_valid && !q_full;

	// classify the event
	always_comb begin
		q_wdata.now_ms = evt.now_ms;
		case (evt.cmd)
			swcm_pkg::CMD_TICK:  q_wdata.kind = swcm_pkg::CMD_TICK;
			swcm_pkg::CMD_MODE:  q_wdata.kind = swcm_pkg::CMD_MODE;
			swcm_pkg::CMD_START: q_wdata.kind = swcm_pkg::CMD_START;
			default:             q_wdata.kind = swcm_pkg::CMD_RESET;
		endcase
	end

endmodule

@@ rtl/swcm_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcm_queue
// Small register queue between the front and the back part.
// ----------------------------------------------------------------------------
module swcm_queue #(
	parameter int unsigned DEPTH = swcm_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  swcm_pkg::op_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          rvalid,
	output swcm_pkg::op_t rdata
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	swcm_pkg::op_t     entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign rvalid = (count_q != '0);
	assign rdata  = entry_q[rd_ptr_q];
	assign do_pop = pop && rvalid;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/swcm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcm_back
// Executes queued events against the stopwatch state, then converts the
// elapsed milliseconds to hours, minutes and seconds in three stages.
// ----------------------------------------------------------------------------
module swcm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  logic                 q_valid,
	input  swcm_pkg::op_t        q_op,
	output logic                 q_pop,
	output logic                 res_valid,
	input  logic                 res_stall,
	output swcm_pkg::res_item_t  res
);

	localparam int unsigned SW = swcm_pkg::SECS_W;
	localparam int unsigned MW = swcm_pkg::MINS_W;
	localparam int unsigned HW = swcm_pkg::HRS_W;

	// architectural state
	logic [15:0]            period_q;
	logic                   mode_q;
	swcm_pkg::run_state_t   state_q;
	logic [31:0]            elapsed_q;
	logic [31:0]            last_upd_q;
	logic [31:0]            last_ref_q;
	logic                   pend_q;

	// next state
	logic                   n_mode;
	swcm_pkg::run_state_t   n_state;
	logic [31:0]            n_elapsed;
	logic [31:0]            n_last_upd;
	logic [31:0]            n_last_ref;
	logic                   n_pend;
	logic                   n_refresh;
	logic                   n_started;
	logic [31:0]            since_upd;
	logic [31:0]            since_ref;

	// pipeline
	logic                   adv;
	logic                   v_s1, v_s2, v_s3, v_s4;
	swcm_pkg::flags_t       flags_s1, flags_s2, flags_s3, flags_s4;
	logic [31:0]            elapsed_s1;
	logic [SW-1:0]          secs_s2;
	logic [MW-1:0]          mins_s3;
	logic [5:0]             sec_rem_s3;
	logic [7:0]             hours_s4;
	logic [5:0]             min_rem_s4;
	logic [5:0]             sec_rem_s4;

	logic [60:0]            ms_prod;
	logic [45:0]            sec_prod;
	logic [MW-1:0]          mins_tot;
	logic [SW-1:0]          mins_x60;
	logic [33:0]            min_prod;
	logic [HW-1:0]          hrs_tot;
	logic [MW-1:0]          hrs_x60;

	// whole pipeline moves unless the output register is held
	assign adv   = !v_s4 || !res_stall;
	assign q_pop = adv && q_valid;

	assign since_upd = q_op.now_ms - last_upd_q;
	assign since_ref = q_op.now_ms - last_ref_q;

	// event execution
	always_comb begin
		n_mode     = mode_q;
		n_state    = state_q;
		n_elapsed  = elapsed_q;
		n_last_upd = last_upd_q;
		n_last_ref = last_ref_q;
		n_pend     = pend_q;
		n_refresh  = 1'b0;
		n_started  = 1'b0;
		case (q_op.kind)
			swcm_pkg::CMD_TICK: begin
				if (mode_q && state_q == swcm_pkg::ST_RUNNING) begin
					n_elapsed  = elapsed_q + since_upd;
					n_last_upd = q_op.now_ms;
				end
				if (pend_q || since_ref >= {16'd0, period_q}) begin
					n_refresh  = 1'b1;
					n_last_ref = q_op.now_ms;
					n_pend     = 1'b0;
				end
			end
			swcm_pkg::CMD_MODE: begin
				n_mode = !mode_q;
				n_pend = 1'b1;
			end
			swcm_pkg::CMD_START: begin
				if (mode_q) begin
					if (state_q == swcm_pkg::ST_RUNNING) begin
						n_state = swcm_pkg::ST_PAUSED;
						n_pend  = 1'b1;
					end else if (state_q == swcm_pkg::ST_IDLE ||
					             state_q == swcm_pkg::ST_PAUSED) begin
						n_state    = swcm_pkg::ST_RUNNING;
						n_last_upd = q_op.now_ms;
						n_pend     = 1'b1;
						n_started  = 1'b1;
					end
				end
			end
			default: begin
				if (mode_q) begin
					n_state   = swcm_pkg::ST_IDLE;
					n_elapsed = '0;
					n_pend    = 1'b1;
				end
			end
		endcase
	end

	// config register and stopwatch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= swcm_pkg::REFRESH_PERIOD_RST;
			mode_q     <= 1'b0;
			state_q    <= swcm_pkg::ST_IDLE;
			elapsed_q  <= '0;
			last_upd_q <= '0;
			last_ref_q <= '0;
			pend_q     <= 1'b1;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (q_pop) begin
				mode_q     <= n_mode;
				state_q    <= n_state;
				elapsed_q  <= n_elapsed;
				last_upd_q <= n_last_upd;
				last_ref_q <= n_last_ref;
				pend_q     <= n_pend;
			end
		end
	end

	// constant-divisor conversions
	assign ms_prod  = 61'(elapsed_s1) * 61'(swcm_pkg::MS_RECIP);
	assign sec_prod = 46'(secs_s2) * 46'(swcm_pkg::SEC_RECIP);
	assign mins_tot = MW'(sec_prod >> swcm_pkg::SEC_SHIFT);
	assign mins_x60 = SW'({mins_tot, 6'd0}) - SW'({mins_tot, 2'd0});
	assign min_prod = 34'(mins_s3) * 34'(swcm_pkg::MIN_RECIP);
	assign hrs_tot  = HW'(min_prod >> swcm_pkg::MIN_SHIFT);
	assign hrs_x60  = MW'({hrs_tot, 6'd0}) - MW'({hrs_tot, 2'd0});

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s1.refresh    <= n_refresh;
			flags_s1.timer_mode <= n_mode;
			flags_s1.run_state  <= n_state;
			flags_s1.started    <= n_started;
			elapsed_s1          <= n_elapsed;

			flags_s2 <= flags_s1;
			secs_s2  <= SW'(ms_prod >> swcm_pkg::MS_SHIFT);

			flags_s3   <= flags_s2;
			mins_s3    <= mins_tot;
			sec_rem_s3 <= 6'(secs_s2 - mins_x60);

			flags_s4   <= flags_s3;
			hours_s4   <= hrs_tot[7:0];
			min_rem_s4 <= 6'(mins_s3 - hrs_x60);
			sec_rem_s4 <= sec_rem_s3;
		end
	end

	// result
	assign res_valid      = v_s4;
	assign res.refresh    = flags_s4.refresh;
	assign res.timer_mode = flags_s4.timer_mode;
	assign res.run_state  = flags_s4.run_state;
	assign res.hours      = hours_s4;
	assign res.minutes    = min_rem_s4;
	assign res.seconds    = sec_rem_s4;
	assign res.started    = flags_s4.started;

endmodule

@@ rtl/stopwatch_with_clock_mode_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stopwatch_with_clock_mode_core
// Stopwatch with clock/timer display mode, decoupled front and back parts.
// ----------------------------------------------------------------------------
// an accepted event passes the queue and the execute stage, then three
//   conversion stages for seconds, minutes and hours, before its result is valid
// throughput: one event per cycle while the result channel is not stalled, set by the execute stage
// reset: arst_n clears the queue, pipeline and state asynchronously; clock
//   mode, idle, zero elapsed time, refresh pending, refresh period 1000 ms
module stopwatch_with_clock_mode_core #(
	parameter int unsigned QUEUE_DEPTH = swcm_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  logic                 evt_valid,
	output logic                 evt_stall,
	input  swcm_pkg::evt_item_t  evt,
	output logic                 res_valid,
	input  logic                 res_stall,
	output swcm_pkg::res_item_t  res
);

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	swcm_pkg::op_t q_wdata;
	swcm_pkg::op_t q_rdata;

	// event intake
	swcm_front u_front (
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	// decoupling queue
	swcm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rvalid (q_valid),
		.rdata  (q_rdata)
	);

	// execution and time conversion
	swcm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_op      (q_rdata),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

@@ rtl/swcm_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcm_chk
// Port-level checks on the result channel of the stopwatch core.
// ----------------------------------------------------------------------------
module swcm_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_stall,
	input swcm_pkg::res_item_t res
);

	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// a start only ever leaves the timer running in timer mode
	a_started: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.started |->
			res.timer_mode && res.run_state == swcm_pkg::ST_RUNNING && !res.refresh)
		else $error("start flag with wrong mode, state or refresh");

	// minutes and seconds stay in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.minutes < 6'd60 && res.seconds < 6'd60)
		else $error("minutes or seconds out of range");

	// idle timer shows zero time
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.run_state == swcm_pkg::ST_IDLE |->
			res.hours == 8'd0 && res.minutes == 6'd0 && res.seconds == 6'd0)
		else $error("idle timer shows nonzero time");

endmodule

bind stopwatch_with_clock_mode_core swcm_chk u_swcm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
